FILE: rtl/core/rtc3w_pkg.sv
// ----------------------------------------------------------------------------
// rtc3w_pkg
// Types, constants and helpers for the 3-wire serial RTC master.
// ----------------------------------------------------------------------------
package rtc3w_pkg;

    localparam int BURST_BYTES = 8;
    localparam logic [2:0] BURST_LAST_IDX = 3'(BURST_BYTES - 1);

    localparam logic [7:0] CMD_BURST_READ = 8'hBF;
    localparam logic [7:0] CMD_READ_BIT   = 8'h01;
    localparam logic [7:0] DEC_MAX        = 8'd99;
    localparam logic [7:0] PHASE_TICKS_RST = 8'd1;

    typedef enum logic [1:0] {
        MODE_RAW_WR    = 2'd0,
        MODE_DEC_WR    = 2'd1,
        MODE_SINGLE_RD = 2'd2,
        MODE_BURST_RD  = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'd0,
        ST_START = 4'd1,
        ST_WLOW  = 4'd2,
        ST_WHIGH = 4'd3,
        ST_RLOW  = 4'd4,
        ST_RHIGH = 4'd5,
        ST_STOP  = 4'd6
    } t_seq;

    // Clamp to 99 and pack as tens:units BCD. Tens via x*205 >> 11 (exact below 1029).
    function automatic logic [7:0] to_bcd(input logic [7:0] value);
        logic [6:0]  v;
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  tens_x10;
        logic [6:0]  units;
        v        = (value > DEC_MAX) ? DEC_MAX[6:0] : value[6:0];
        prod     = 15'(v) * 15'd205;
        tens     = prod[14:11];
        tens_x10 = {tens[2:0], 3'b000} + {1'b0, tens[3:0], 1'b0} + 7'({tens[3], 6'b0});
        units    = v - tens_x10;
        return {tens, units[3:0]};
    endfunction

    // Bits 6:4 times ten plus bits 3:0.
    function automatic logic [6:0] from_bcd(input logic [7:0] raw);
        logic [6:0] hi_x10;
        hi_x10 = {1'b0, raw[6:4], 3'b000} + {3'b000, raw[6:4], 1'b0};
        return hi_x10 + {3'b000, raw[3:0]};
    endfunction

endpackage

FILE: rtl/core/rtc_three_wire_serial_master.sv
// ----------------------------------------------------------------------------
// rtc_three_wire_serial_master
// Tick-driven CE/SCLK/IO sequencer for a 3-wire serial real-time clock.
//
// Channel   Direction  Handshake                 Payload
// in        sink       i_in_valid / o_in_stall   start_req, mode, address,
//                                                write_data, io_in
// out       source     o_out_valid / i_out_stall pin levels, busy, read byte
// cfg       sink       i_cfg_valid / o_cfg_ready phase_ticks
//
// One tick per cycle while the output is not stalled: each accepted tick updates
// the sequencer and loads one result into the output register on the same edge.
// The output register is the only storage between the sides, so a tick is
// taken in the cycle the pending result is taken.
// Synchronous active-low reset: sequencer idle, output valid low, phase_ticks 1.
// Config writes are always ready.
// ----------------------------------------------------------------------------
module rtc_three_wire_serial_master (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input ticks
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_start_req,
    input  logic [1:0] i_mode,
    input  logic [7:0] i_address,
    input  logic [7:0] i_write_data,
    input  logic       i_io_in,
    // results
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_chip_enable,
    output logic       o_serial_clock,
    output logic       o_data_out,
    output logic       o_data_drive,
    output logic       o_busy_res,
    output logic       o_byte_valid,
    output logic [7:0] o_raw_byte,
    output logic [6:0] o_decimal_value,
    output logic [2:0] o_byte_index,
    output logic       o_last_byte,
    // configuration
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);
    import rtc3w_pkg::*;

    t_seq       r_state,   n_state;
    logic [2:0] r_bit,     n_bit;
    logic [2:0] r_byte,    n_byte;
    logic [7:0] r_shift,   n_shift;
    logic [7:0] r_hold,    n_hold;
    t_mode      r_mode,    n_mode;
    logic [7:0] r_phase,   n_phase;
    logic [7:0] r_phase_ticks;

    logic       r_out_valid;
    logic       r_ce, r_sclk, r_dout, r_drv, r_busy;
    logic       r_bvalid, r_last;
    logic [7:0] r_raw;
    logic [6:0] r_dec;
    logic [2:0] r_idx;

    logic       n_ce, n_sclk, n_dout, n_drv;
    logic       n_bvalid, n_last;
    logic [7:0] n_raw;
    logic [2:0] n_idx;
    logic [2:0] bit_inc;
    logic       phase_end;
    logic       in_accept;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign bit_inc   = r_bit + 3'd1;
    // zero phase_ticks falls through like 1
    assign phase_end = !(({1'b0, r_phase} + 9'd1) < {1'b0, r_phase_ticks});

    // next state
    always_comb begin
        n_state  = r_state;
        n_bit    = r_bit;
        n_byte   = r_byte;
        n_shift  = r_shift;
        n_hold   = r_hold;
        n_mode   = r_mode;
        n_phase  = r_phase;
        n_bvalid = 1'b0;
        n_raw    = 8'd0;
        n_idx    = 3'd0;
        n_last   = 1'b0;
        if (in_accept) begin
            if (r_state == ST_IDLE) begin
                if (i_start_req) begin
                    n_mode = t_mode'(i_mode);
                    n_hold = (t_mode'(i_mode) == MODE_DEC_WR) ? to_bcd(i_write_data)
                                                              : i_write_data;
                    case (t_mode'(i_mode))
                        MODE_SINGLE_RD: n_shift = i_address | CMD_READ_BIT;
                        MODE_BURST_RD:  n_shift = CMD_BURST_READ;
                        default:        n_shift = i_address;
                    endcase
                    n_bit   = 3'd0;
                    n_byte  = 3'd0;
                    n_phase = 8'd0;
                    n_state = ST_START;
                end
            end else if (!phase_end) begin
                n_phase = r_phase + 8'd1;
            end else begin
                n_phase = 8'd0;
                case (r_state)
                    ST_START: n_state = ST_WLOW;
                    ST_WLOW:  n_state = ST_WHIGH;
                    ST_WHIGH: begin
                        n_shift = {1'b0, r_shift[7:1]};
                        n_bit   = bit_inc;
                        if (bit_inc != 3'd0) begin
                            n_state = ST_WLOW;
                        end else if (r_mode == MODE_RAW_WR || r_mode == MODE_DEC_WR) begin
                            if (r_byte == 3'd0) begin
                                n_shift = r_hold;
                                n_byte  = 3'd1;
                                n_state = ST_WLOW;
                            end else begin
                                n_state = ST_STOP;
                            end
                        end else begin
                            n_shift = 8'd0;
                            n_byte  = 3'd0;
                            n_state = ST_RLOW;
                        end
                    end
                    ST_RLOW: begin
                        n_shift = {i_io_in, r_shift[7:1]};
                        n_bit   = bit_inc;
                        if (bit_inc == 3'd0) begin
                            n_bvalid = 1'b1;
                            n_raw    = {i_io_in, r_shift[7:1]};
                            n_idx    = r_byte;
                            n_last   = (r_mode == MODE_SINGLE_RD) || (r_byte == BURST_LAST_IDX);
                            if (n_last) begin
                                n_state = ST_STOP;
                            end else begin
                                n_byte  = r_byte + 3'd1;
                                n_state = ST_RHIGH;
                            end
                        end else begin
                            n_state = ST_RHIGH;
                        end
                    end
                    ST_RHIGH: n_state = ST_RLOW;
                    default:  n_state = ST_IDLE;
                endcase
            end
        end
    end

    // pin decode from the state after the tick
    always_comb begin
        n_ce   = 1'b0;
        n_sclk = 1'b0;
        n_dout = 1'b0;
        n_drv  = 1'b0;
        case (n_state)
            ST_START: n_ce = 1'b1;
            ST_WLOW: begin
                n_ce   = 1'b1;
                n_drv  = 1'b1;
                n_dout = n_shift[0];
            end
            ST_WHIGH: begin
                n_ce   = 1'b1;
                n_sclk = 1'b1;
                n_drv  = 1'b1;
                n_dout = n_shift[0];
            end
            ST_RLOW:  n_ce = 1'b1;
            ST_RHIGH: begin
                n_ce   = 1'b1;
                n_sclk = 1'b1;
            end
            ST_STOP: begin
                n_ce   = 1'b1;
                n_sclk = 1'b1;
            end
            default: begin
                n_ce = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_bit         <= 3'd0;
            r_byte        <= 3'd0;
            r_shift       <= 8'd0;
            r_hold        <= 8'd0;
            r_mode        <= MODE_RAW_WR;
            r_phase       <= 8'd0;
            r_phase_ticks <= PHASE_TICKS_RST;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_bit   <= n_bit;
            r_byte  <= n_byte;
            r_shift <= n_shift;
            r_hold  <= n_hold;
            r_mode  <= n_mode;
            r_phase <= n_phase;
            if (i_cfg_valid) begin
                r_phase_ticks <= i_cfg_data;
            end
            if (in_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_ce     <= n_ce;
            r_sclk   <= n_sclk;
            r_dout   <= n_dout;
            r_drv    <= n_drv;
            r_busy   <= (n_state != ST_IDLE);
            r_bvalid <= n_bvalid;
            r_raw    <= n_raw;
            r_dec    <= from_bcd(n_raw);
            r_idx    <= n_idx;
            r_last   <= n_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_chip_enable   = r_ce;
    assign o_serial_clock  = r_sclk;
    assign o_data_out      = r_dout;
    assign o_data_drive    = r_drv;
    assign o_busy_res      = r_busy;
    assign o_byte_valid    = r_bvalid;
    assign o_raw_byte      = r_raw;
    assign o_decimal_value = r_dec;
    assign o_byte_index    = r_idx;
    assign o_last_byte     = r_last;

    a_drive_needs_ce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_data_drive |-> o_chip_enable)
        else $error("IO driven with CE low");

    a_idle_pins_rest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_busy_res |-> !o_chip_enable && !o_serial_clock && !o_data_drive)
        else $error("pins not at rest while idle");

    a_read_byte_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_byte_valid |-> o_chip_enable && o_serial_clock && !o_data_drive)
        else $error("read byte completed outside a released high phase");

    a_idle_counters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE && in_accept && i_start_req |=> r_bit == 3'd0 && r_phase == 8'd0)
        else $error("transaction start did not clear counters");

endmodule
